FILE: rtl/core/erd_pkg.sv
`timescale 1ns / 1ps
package erd_pkg;

  localparam int MANT_W = 64;
  localparam int SE_W   = 16;
  localparam int EXP_W  = 18;
  localparam int CNT_W  = 7;

  localparam logic [EXP_W-1:0] EXP_BIAS = EXP_W'(16383);
  localparam logic [EXP_W-1:0] EXP_MAX  = EXP_W'(16'h7fff);
  localparam logic [CNT_W-1:0] STEPS    = CNT_W'(64);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM_DEN,
    ST_DIVIDE,
    ST_NORM_QUO,
    ST_FINISH
  } erd_state_t;

  typedef struct packed {
    logic load;
    logic den_shift;
    logic div_step;
    logic quo_shift;
  } erd_ctrl_t;

  typedef struct packed {
    logic den_top;
    logic quo_top;
    logic quo_zero;
    logic exp_zero;
    logic last_step;
  } erd_stat_t;

endpackage

FILE: rtl/core/erd_ctrl.sv
`timescale 1ns / 1ps
module erd_ctrl
  import erd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  logic      early_done,
  input  erd_stat_t stat,
  output erd_ctrl_t ctrl,
  output logic      busy,
  output logic      finish
);

  erd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go && !early_done) state_nxt = ST_NORM_DEN;
      end
      ST_NORM_DEN: begin
        if (stat.den_top) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.last_step) state_nxt = ST_NORM_QUO;
      end
      ST_NORM_QUO: begin
        if (stat.quo_zero || stat.quo_top || stat.exp_zero) state_nxt = ST_FINISH;
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    busy      = 1'b1;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = go;
      end
      ST_NORM_DEN: ctrl.den_shift = !stat.den_top;
      ST_DIVIDE:   ctrl.div_step  = 1'b1;
      ST_NORM_QUO: ctrl.quo_shift = !(stat.quo_zero || stat.quo_top || stat.exp_zero);
      ST_FINISH:   finish = 1'b1;
      default:     busy = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/erd_dpath.sv
`timescale 1ns / 1ps
module erd_dpath
  import erd_pkg::*;
(
  input  logic              clk,
  input  erd_ctrl_t         ctrl,
  input  logic [SE_W-1:0]   se1,
  input  logic [SE_W-1:0]   se2,
  input  logic [MANT_W-1:0] m1,
  input  logic [MANT_W-1:0] m2,
  output erd_stat_t         stat,
  output logic [EXP_W-1:0]  expo,
  output logic [MANT_W-1:0] quo,
  output logic              sign
);

  logic [MANT_W-1:0] rem_r, rem_nxt, den_r, den_nxt, quo_r, quo_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic              carry_r, carry_nxt, sign_r, sign_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MANT_W-1:0] diff;
  logic              take;

  assign take = carry_r || (rem_r >= den_r);
  assign diff = take ? rem_r - den_r : rem_r;

  always_comb begin
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    exp_nxt   = exp_r;
    carry_nxt = carry_r;
    sign_nxt  = sign_r;
    cnt_nxt   = cnt_r;
    if (ctrl.load) begin
      rem_nxt   = m1;
      den_nxt   = m2;
      quo_nxt   = '0;
      carry_nxt = 1'b0;
      cnt_nxt   = '0;
      sign_nxt  = se1[SE_W-1] ^ se2[SE_W-1];
      exp_nxt   = EXP_W'(se1[SE_W-2:0]) - EXP_W'(se2[SE_W-2:0]) + EXP_BIAS;
    end
    if (ctrl.den_shift) begin
      den_nxt = den_r << 1;
      exp_nxt = exp_r + 1'b1;
    end
    if (ctrl.div_step) begin
      quo_nxt   = {quo_r[MANT_W-2:0], take};
      carry_nxt = diff[MANT_W-1];
      rem_nxt   = diff << 1;
      cnt_nxt   = cnt_r + 1'b1;
    end
    if (ctrl.quo_shift) begin
      quo_nxt = quo_r << 1;
      exp_nxt = exp_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    quo_r   <= quo_nxt;
    exp_r   <= exp_nxt;
    carry_r <= carry_nxt;
    sign_r  <= sign_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign stat.den_top   = den_r[MANT_W-1];
  assign stat.quo_top   = quo_r[MANT_W-1];
  assign stat.quo_zero  = (quo_r == '0);
  assign stat.exp_zero  = (exp_r == '0);
  assign stat.last_step = (cnt_r == STEPS - 1'b1);
  assign expo = exp_r;
  assign quo  = quo_r;
  assign sign = sign_r;

endmodule

FILE: rtl/core/extended_real_divider.sv
`timescale 1ns / 1ps
// Zero-divide and underflow requests are answered straight from idle; other requests
// normalise the divisor, take one divide step per quotient bit, then normalise the quotient.
// One request at a time; busy stays high until out_valid unless answered from idle.
// out_valid is high for exactly one cycle per result; the receiver cannot stall.
// Reset: synchronous active-low rst_n clears the sequencer and out_valid.
module extended_real_divider
  import erd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [SE_W-1:0]   in_dividend_sign_exponent,
  input  logic [MANT_W-1:0] in_dividend_mantissa,
  input  logic [SE_W-1:0]   in_divisor_sign_exponent,
  input  logic [MANT_W-1:0] in_divisor_mantissa,
  output logic              out_valid,
  output logic [SE_W-1:0]   out_quotient_sign_exponent,
  output logic [MANT_W-1:0] out_quotient_mantissa,
  output logic              out_result_written,
  output logic              out_zero_divide,
  output logic              out_underflow,
  output logic              out_denormal,
  output logic              out_overflow
);

  erd_ctrl_t         ctrl;
  erd_stat_t         stat;
  logic              finish, go, early, zdiv, unf;
  logic [EXP_W-1:0]  expo, pre_exp, fin_exp;
  logic [MANT_W-1:0] quo;
  logic              sign, ovf;

  assign go      = start && !busy;
  assign zdiv    = (in_divisor_mantissa == '0);
  assign pre_exp = EXP_W'(in_dividend_sign_exponent[SE_W-2:0])
                 - EXP_W'(in_divisor_sign_exponent[SE_W-2:0]) + EXP_BIAS;
  assign unf     = pre_exp[EXP_W-1];
  assign early   = zdiv || unf;

  erd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(go), .early_done(early), .stat(stat),
    .ctrl(ctrl), .busy(busy), .finish(finish)
  );

  erd_dpath u_dpath (
    .clk(clk), .ctrl(ctrl),
    .se1(in_dividend_sign_exponent), .se2(in_divisor_sign_exponent),
    .m1(in_dividend_mantissa), .m2(in_divisor_mantissa),
    .stat(stat), .expo(expo), .quo(quo), .sign(sign)
  );

  assign fin_exp = stat.quo_zero ? '0 : expo;
  assign ovf     = (fin_exp > EXP_MAX);

  logic              valid_r;
  logic [SE_W-1:0]   se_r;
  logic [MANT_W-1:0] mant_r;
  logic              wr_r, zd_r, uf_r, dn_r, of_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (go && early) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if (go && early) begin
      mant_r <= '0;
      zd_r   <= zdiv;
      uf_r   <= !zdiv;
      wr_r   <= !zdiv;
      dn_r   <= 1'b0;
      of_r   <= 1'b0;
      se_r   <= zdiv ? '0 : {in_dividend_sign_exponent[SE_W-1]
                             ^ in_divisor_sign_exponent[SE_W-1], (SE_W-1)'(0)};
    end else if (finish) begin
      zd_r   <= 1'b0;
      uf_r   <= 1'b0;
      of_r   <= ovf;
      wr_r   <= !ovf;
      dn_r   <= !ovf && !stat.quo_zero && !stat.quo_top;
      mant_r <= ovf ? '0 : quo;
      se_r   <= ovf ? '0 : {sign, fin_exp[SE_W-2:0]};
    end
  end

  assign out_valid                  = valid_r;
  assign out_quotient_sign_exponent = se_r;
  assign out_quotient_mantissa      = mant_r;
  assign out_result_written         = wr_r;
  assign out_zero_divide            = zd_r;
  assign out_underflow              = uf_r;
  assign out_denormal               = dn_r;
  assign out_overflow               = of_r;

`ifndef NO_ASSERTIONS
  a_busy_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> !busy) else $error("busy after finish");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_zero_divide, out_underflow, out_overflow}) <= 1)
    else $error("multiple exception flags");
  a_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_written == !(out_zero_divide || out_overflow)))
    else $error("result_written mismatch");
`endif

endmodule
